// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DCF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcf77 decoder assertion failed");

// next-cycle implication
`define DCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcf77 decoder assertion failed");

`endif

// ===== hdl/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types, register indexes, reset values and BCD weights for the
// DCF77 time code decoder.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int CFG_W  = 16;
    localparam int TS_W   = 32;
    localparam int TIME_W = 13;
    localparam int DATE_W = 19;

    typedef enum logic [1:0] {
        CFG_SHORT_MIN  = 2'd0,
        CFG_LONG_MIN   = 2'd1,
        CFG_LONG_END   = 2'd2,
        CFG_MARKER_MIN = 2'd3
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd50;
    localparam logic [CFG_W-1:0] LONG_MIN_RST   = 16'd150;
    localparam logic [CFG_W-1:0] LONG_END_RST   = 16'd250;
    localparam logic [CFG_W-1:0] MARKER_MIN_RST = 16'd1500;

    // pulse classification of one edge interval
    typedef struct packed {
        logic is_zero;
        logic is_one;
        logic marker;
    } pulse_class_t;

    // per-item result handed to the output register
    typedef struct packed {
        logic              frame_end;
        logic              time_valid;
        logic [TIME_W-1:0] time_code;
        logic [DATE_W-1:0] date_code;
    } frame_result_t;

    // BCD weight of the n-th bit of a field: 1,2,4,8,10,20,40,80
    function automatic logic [7:0] bcd_weight(input logic [2:0] idx);
        logic [7:0] w;
        case (idx)
            3'd0:    w = 8'd1;
            3'd1:    w = 8'd2;
            3'd2:    w = 8'd4;
            3'd3:    w = 8'd8;
            3'd4:    w = 8'd10;
            3'd5:    w = 8'd20;
            3'd6:    w = 8'd40;
            3'd7:    w = 8'd80;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/dcf_interval.sv =====
// ----------------------------------------------------------------------------
// dcf_interval
// Edge-to-edge interval (mod 2^32) and threshold classification; holds the
// previous edge timestamp.
// ----------------------------------------------------------------------------
module dcf_interval (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [dcf_pkg::TS_W-1:0]     timestamp_ms,
    input  logic [dcf_pkg::CFG_W-1:0]    short_min_ms,
    input  logic [dcf_pkg::CFG_W-1:0]    long_min_ms,
    input  logic [dcf_pkg::CFG_W-1:0]    long_end_ms,
    input  logic [dcf_pkg::CFG_W-1:0]    marker_min_ms,
    output dcf_pkg::pulse_class_t        cls
);

    logic [dcf_pkg::TS_W-1:0] last_edge_reg;
    logic [dcf_pkg::TS_W-1:0] dt;

    assign dt = timestamp_ms - last_edge_reg;

    always_comb
    begin
        cls.is_zero = (dt >= 32'(short_min_ms)) && (dt < 32'(long_min_ms));
        cls.is_one  = (dt >= 32'(long_min_ms))  && (dt < 32'(long_end_ms));
        cls.marker  = (dt >= 32'(marker_min_ms));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
        end
        else if (step)
        begin
            last_edge_reg <= timestamp_ms;
        end
    end

endmodule

// ===== hdl/dcf_frame.sv =====
// ----------------------------------------------------------------------------
// dcf_frame
// Frame state: bit counter, BCD field accumulation, parity checks, frame
// judgement at the minute marker and the held time/date codes.
// ----------------------------------------------------------------------------
module dcf_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  dcf_pkg::pulse_class_t  cls,
    output dcf_pkg::frame_result_t res
);

    localparam logic signed [7:0] CNT_MAX    = 8'sd127;
    localparam logic signed [7:0] DATA_START = 8'sd20;
    localparam logic signed [7:0] MIN_FIRST  = 8'sd21;
    localparam logic signed [7:0] MIN_LAST   = 8'sd27;
    localparam logic signed [7:0] MIN_PAR    = 8'sd28;
    localparam logic signed [7:0] HOUR_FIRST = 8'sd29;
    localparam logic signed [7:0] HOUR_LAST  = 8'sd34;
    localparam logic signed [7:0] HOUR_PAR   = 8'sd35;
    localparam logic signed [7:0] DAY_FIRST  = 8'sd36;
    localparam logic signed [7:0] DAY_LAST   = 8'sd41;
    localparam logic signed [7:0] MON_FIRST  = 8'sd45;
    localparam logic signed [7:0] MON_LAST   = 8'sd49;
    localparam logic signed [7:0] YEAR_FIRST = 8'sd50;
    localparam logic signed [7:0] YEAR_LAST  = 8'sd57;
    localparam logic signed [7:0] FRAME_BITS = 8'sd58;

    logic signed [7:0]             cnt_reg, cnt_next;
    logic                          bitv_reg, bitv_next;
    logic [6:0]                    min_reg, min_next;
    logic [5:0]                    hour_reg, hour_next;
    logic [5:0]                    day_reg, day_next;
    logic [4:0]                    mon_reg, mon_next;
    logic [7:0]                    year_reg, year_next;
    logic                          min_odd_reg, min_odd_next;
    logic                          hour_odd_reg, hour_odd_next;
    logic                          par_ok_reg, par_ok_next;
    logic                          good_reg, good_next;
    logic [dcf_pkg::TIME_W-1:0]    time_reg, time_next;
    logic [dcf_pkg::DATE_W-1:0]    date_reg, date_next;

    logic [7:0]                    wt;
    logic [19:0]                   date_full;

    always_comb
    begin
        cnt_next      = cnt_reg;
        bitv_next     = bitv_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        mon_next      = mon_reg;
        year_next     = year_reg;
        min_odd_next  = min_odd_reg;
        hour_odd_next = hour_odd_reg;
        par_ok_next   = par_ok_reg;
        good_next     = good_reg;
        time_next     = time_reg;
        date_next     = date_reg;
        wt            = '0;
        date_full     = '0;

        if (cls.is_zero || cls.is_one)
        begin
            if (cnt_next < CNT_MAX)
                cnt_next = cnt_next + 8'sd1;
            if (cnt_next > DATA_START)
                bitv_next = cls.is_one;
            if (par_ok_next)
            begin
                if (cnt_next >= MIN_FIRST && cnt_next <= MIN_LAST)
                begin
                    wt = dcf_pkg::bcd_weight(3'(cnt_next[2:0] - MIN_FIRST[2:0]));
                    if (bitv_next)
                    begin
                        min_next     = min_next + wt[6:0];
                        min_odd_next = !min_odd_next;
                    end
                end
                else if (cnt_next == MIN_PAR)
                begin
                    if (bitv_next != min_odd_next)
                        par_ok_next = 1'b0;
                end
                else if (cnt_next >= HOUR_FIRST && cnt_next <= HOUR_LAST)
                begin
                    wt = dcf_pkg::bcd_weight(3'(cnt_next[2:0] - HOUR_FIRST[2:0]));
                    if (bitv_next)
                    begin
                        hour_next     = hour_next + wt[5:0];
                        hour_odd_next = !hour_odd_next;
                    end
                end
                else if (cnt_next == HOUR_PAR)
                begin
                    if (bitv_next != hour_odd_next)
                        par_ok_next = 1'b0;
                end
                else if (cnt_next >= DAY_FIRST && cnt_next <= DAY_LAST)
                begin
                    wt = dcf_pkg::bcd_weight(3'(cnt_next[2:0] - DAY_FIRST[2:0]));
                    if (bitv_next)
                        day_next = day_next + wt[5:0];
                end
                else if (cnt_next >= MON_FIRST && cnt_next <= MON_LAST)
                begin
                    wt = dcf_pkg::bcd_weight(3'(cnt_next[2:0] - MON_FIRST[2:0]));
                    if (bitv_next)
                        mon_next = mon_next + wt[4:0];
                end
                else if (cnt_next >= YEAR_FIRST && cnt_next <= YEAR_LAST)
                begin
                    wt = dcf_pkg::bcd_weight(3'(cnt_next[2:0] - YEAR_FIRST[2:0]));
                    if (bitv_next)
                        year_next = year_next + wt;
                end
            end
        end

        // marker judges the frame after any data bit of the same edge
        if (cls.marker)
        begin
            good_next = (cnt_next == FRAME_BITS) && par_ok_next;
            date_full = 20'(day_next) * 20'd10000 + 20'(mon_next) * 20'd100
                      + 20'(year_next);
            if (good_next)
            begin
                time_next = 13'(hour_next) * 13'd100 + 13'(min_next);
                date_next = date_full[dcf_pkg::DATE_W-1:0];
            end
            cnt_next      = -8'sd1;
            min_next      = '0;
            hour_next     = '0;
            day_next      = '0;
            mon_next      = '0;
            year_next     = '0;
            min_odd_next  = 1'b0;
            hour_odd_next = 1'b0;
            par_ok_next   = 1'b1;
        end
    end

    always_comb
    begin
        res.frame_end  = cls.marker;
        res.time_valid = good_next;
        res.time_code  = time_next;
        res.date_code  = date_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            bitv_reg     <= 1'b0;
            min_reg      <= '0;
            hour_reg     <= '0;
            day_reg      <= '0;
            mon_reg      <= '0;
            year_reg     <= '0;
            min_odd_reg  <= 1'b0;
            hour_odd_reg <= 1'b0;
            par_ok_reg   <= 1'b1;
            good_reg     <= 1'b0;
            time_reg     <= '0;
            date_reg     <= '0;
        end
        else if (step)
        begin
            cnt_reg      <= cnt_next;
            bitv_reg     <= bitv_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            day_reg      <= day_next;
            mon_reg      <= mon_next;
            year_reg     <= year_next;
            min_odd_reg  <= min_odd_next;
            hour_odd_reg <= hour_odd_next;
            par_ok_reg   <= par_ok_next;
            good_reg     <= good_next;
            time_reg     <= time_next;
            date_reg     <= date_next;
        end
    end

endmodule

// ===== hdl/dcf77_time_code_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder_unit
// DCF77 time code decoder: classifies receiver edge intervals into data bits
// and minute markers, accumulates BCD time/date, latches good frames.
// ----------------------------------------------------------------------------
//  channel | signals                       | word
//  --------+-------------------------------+---------------------------------
//  in      | s_tvalid s_tready s_tdata     | timestamp_ms[31:0]
//  out     | m_tvalid m_tready m_tdata     | time_code[12:0], date_code[31:13]
//          | m_tlast m_tuser               | tlast=frame_end, tuser=time_valid
//  cfg     | cfg_we cfg_addr cfg_wdata     | 16-bit threshold write, no wait
//
//  One word in, one word out; a new word is taken every cycle while the output
//  is not stalled. A word passes the input register, then one pass of interval
//  compare and frame update into the output register.
//  Output stall holds the output register; the input register still takes
//  one more word, then s_tready follows m_tready.
//  rst_n (async) restores thresholds 50/150/250/1500 ms and clears frame state.
// ----------------------------------------------------------------------------
module dcf77_time_code_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] timestamp_ms
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [12:0] time_code, [31:13] date_code
    output logic                        m_tlast,   // frame_end
    output logic [0:0]                  m_tuser,   // [0] time_valid
    // configuration
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [dcf_pkg::CFG_W-1:0]   cfg_wdata
);

    // threshold registers
    logic [dcf_pkg::CFG_W-1:0] short_min_reg;
    logic [dcf_pkg::CFG_W-1:0] long_min_reg;
    logic [dcf_pkg::CFG_W-1:0] long_end_reg;
    logic [dcf_pkg::CFG_W-1:0] marker_min_reg;

    // input register
    logic                      in_valid_reg;
    logic [dcf_pkg::TS_W-1:0]  in_ts_reg;

    // output register
    logic                      out_valid_reg;
    dcf_pkg::frame_result_t    out_reg;

    logic                      advance;
    dcf_pkg::pulse_class_t     cls;
    dcf_pkg::frame_result_t    res;

    // the item in the input register is processed when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg  <= dcf_pkg::SHORT_MIN_RST;
            long_min_reg   <= dcf_pkg::LONG_MIN_RST;
            long_end_reg   <= dcf_pkg::LONG_END_RST;
            marker_min_reg <= dcf_pkg::MARKER_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dcf_pkg::CFG_SHORT_MIN:  short_min_reg  <= cfg_wdata;
                dcf_pkg::CFG_LONG_MIN:   long_min_reg   <= cfg_wdata;
                dcf_pkg::CFG_LONG_END:   long_end_reg   <= cfg_wdata;
                dcf_pkg::CFG_MARKER_MIN: marker_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ts_reg <= s_tdata;
        end
    end

    dcf_interval u_interval (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .timestamp_ms  (in_ts_reg),
        .short_min_ms  (short_min_reg),
        .long_min_ms   (long_min_reg),
        .long_end_ms   (long_end_reg),
        .marker_min_ms (marker_min_reg),
        .cls           (cls)
    );

    dcf_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cls   (cls),
        .res   (res)
    );

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg.date_code, out_reg.time_code};
    assign m_tlast    = out_reg.frame_end;
    assign m_tuser[0] = out_reg.time_valid;

endmodule

// ===== hdl/dcf_checker.sv =====
// ----------------------------------------------------------------------------
// dcf_checker
// Port-level assertions for the decoder, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [31:0]               m_tdata,
    input logic                      m_tlast,
    input logic [0:0]                m_tuser
);

    // stalled output word holds
    `DCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `DCF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable({m_tdata, m_tlast, m_tuser}))

    // an empty output slot never blocks the input
    `DCF_ASSERT_IMPL(a_ready_when_empty, !m_tvalid || m_tready, s_tready)

    // an accepted word is followed, behind the input and output registers, by a valid output word
    `DCF_ASSERT_IMPL(a_latency, s_tvalid && s_tready, ##2 m_tvalid)

endmodule

bind dcf77_time_code_decoder_unit dcf_checker u_dcf_checker (.*);
